[hw/rtl/capsule_capsule_overlap_macros.svh]
`ifndef CAPSULE_CAPSULE_OVERLAP_MACROS_SVH
`define CAPSULE_CAPSULE_OVERLAP_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define CCO_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cco assertion failed");

// next-cycle implication
`define CCO_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cco assertion failed");

`endif

[hw/rtl/cco_pkg.sv]
`timescale 1ns / 1ps

package cco_pkg;

   localparam int T_BITS    = 17;
   localparam int T_SHIFT   = 16;
   localparam int DIV_STEPS = T_BITS;

   typedef logic [T_BITS-1:0] frac_type;

endpackage

[hw/rtl/cco_req_if.sv]
`timescale 1ns / 1ps

interface cco_req_if;
   logic        valid;
   logic        ready;
   logic [47:0] seg_a_start;
   logic [47:0] seg_a_end;
   logic [15:0] radius_a;
   logic [47:0] seg_b_start;
   logic [47:0] seg_b_end;
   logic [15:0] radius_b;

   modport source (
      output valid, seg_a_start, seg_a_end, radius_a, seg_b_start, seg_b_end, radius_b,
      input  ready
   );
   modport sink (
      input  valid, seg_a_start, seg_a_end, radius_a, seg_b_start, seg_b_end, radius_b,
      output ready
   );
endinterface

[hw/rtl/cco_rsp_if.sv]
`timescale 1ns / 1ps

interface cco_rsp_if;
   logic valid;
   logic ready;
   logic overlap;

   modport source (output valid, overlap, input ready);
   modport sink (input valid, overlap, output ready);
endinterface

[hw/rtl/capsule_capsule_overlap.sv]
`timescale 1ns / 1ps

// channel   dir  beat
// req_bus   in   two segments (3 x Q8.8 each end) and two Q8.8 radii
// rsp_bus   out  overlap flag
//
// One pair per cycle unless the skid register is full, which stalls the pipeline.
// The depth is set by the two 17-stage quotient dividers for t0 and t1.
// Reset is synchronous and clears only the valid bits.
// A stalled result parks in a skid register; req ready drops while it is full or in reset.
module capsule_capsule_overlap #(
   parameter int COORD_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   cco_req_if.sink   req_bus,
   cco_rsp_if.source rsp_bus
);

   localparam int CW     = COORD_WIDTH;
   localparam int DW     = CW + 1;
   localparam int DOTW   = 2 * DW + 2;
   localparam int PW     = 2 * DOTW + 1;
   localparam int UW     = PW - 1;
   localparam int TW     = cco_pkg::T_BITS;
   localparam int GW     = DW + TW + 2;
   localparam int SQW    = 2 * GW;
   localparam int SUMW   = SQW + 2;
   localparam int RSW    = CW + 1;
   localparam int SIDE_W = 9 * DW + RSW;
   localparam int DIV_LO = 6;
   localparam int SIDE_N = DIV_LO + cco_pkg::DIV_STEPS;
   localparam int G_ST   = SIDE_N;
   localparam int NST    = G_ST + 3;

   logic en;
   logic acc;
   logic skid_v_ff, skid_d_ff;
   logic rsp_v_ff, rsp_d_ff;
   logic [NST-1:0] v_ff;

   assign en            = !skid_v_ff;
   assign req_bus.ready = !skid_v_ff && !reset;
   assign acc           = req_bus.valid && req_bus.ready;

   // stage 1: differences
   logic [SIDE_W-1:0] side_in;
   logic [SIDE_W-1:0] side_ff [SIDE_N];

   always_comb begin
      logic [63:0] ea1, ea2, eb1, eb2, era, erb;
      logic [CW-1:0] p1, p2, p3, p4;
      logic signed [DW-1:0] d0, d1, vv;
      ea1 = {16'b0, req_bus.seg_a_start};
      ea2 = {16'b0, req_bus.seg_a_end};
      eb1 = {16'b0, req_bus.seg_b_start};
      eb2 = {16'b0, req_bus.seg_b_end};
      era = {48'b0, req_bus.radius_a};
      erb = {48'b0, req_bus.radius_b};
      side_in = '0;
      for (int k = 0; k < 3; k++) begin
         p1 = ea1[k*CW +: CW];
         p2 = ea2[k*CW +: CW];
         p3 = eb1[k*CW +: CW];
         p4 = eb2[k*CW +: CW];
         d0 = DW'($signed(p2)) - DW'($signed(p1));
         d1 = DW'($signed(p4)) - DW'($signed(p3));
         vv = DW'($signed(p1)) - DW'($signed(p3));
         side_in[k*DW +: DW]     = d0;
         side_in[(3+k)*DW +: DW] = d1;
         side_in[(6+k)*DW +: DW] = vv;
      end
      side_in[9*DW +: RSW] = RSW'(era[CW-1:0]) + RSW'(erb[CW-1:0]);
   end

   // stage 2: dot products
   logic signed [DOTW-1:0] a_in, b_in, c_in, e_in, f_in;
   logic signed [DOTW-1:0] a_ff, b_ff, c_ff, e_ff, f_ff;

   always_comb begin
      logic signed [DW-1:0] d0, d1, vv;
      a_in = '0; b_in = '0; c_in = '0; e_in = '0; f_in = '0;
      for (int k = 0; k < 3; k++) begin
         d0 = $signed(side_ff[0][k*DW +: DW]);
         d1 = $signed(side_ff[0][(3+k)*DW +: DW]);
         vv = $signed(side_ff[0][(6+k)*DW +: DW]);
         a_in = a_in + DOTW'(d0) * DOTW'(d0);
         b_in = b_in + DOTW'(d0) * DOTW'(d1);
         c_in = c_in + DOTW'(d0) * DOTW'(vv);
         e_in = e_in + DOTW'(d1) * DOTW'(d1);
         f_in = f_in + DOTW'(d1) * DOTW'(vv);
      end
   end

   // stage 3: cross products
   logic signed [PW-1:0] ae_ff, bb_ff, bf_ff, ce_ff, af_ff, bc_ff;
   logic signed [DOTW-1:0] a3_ff, b3_ff, c3_ff, e3_ff, f3_ff;

   // stage 4: determinant and numerators
   logic signed [PW-1:0] den_ff, num0_ff, num1_ff;
   logic signed [DOTW-1:0] a4_ff, b4_ff, c4_ff, e4_ff, f4_ff;

   // stage 5: case selection
   logic signed [PW-1:0] n0_in, d0s_in, n1_in, d1s_in;
   logic signed [PW-1:0] n0_ff, d0s_ff, n1_ff, d1s_ff;

   always_comb begin
      logic gen, lo0, hi0, lo1, hi1, out0, out1;
      logic signed [PW-1:0] one, zero, aw, bw, cw_, ew, fw;
      one  = PW'(1);
      zero = '0;
      aw   = PW'(a4_ff);
      bw   = PW'(b4_ff);
      cw_  = PW'(c4_ff);
      ew   = PW'(e4_ff);
      fw   = PW'(f4_ff);
      gen  = !den_ff[PW-1] && (den_ff != '0);
      lo0  = num0_ff[PW-1];
      hi0  = !lo0 && (num0_ff > den_ff);
      lo1  = num1_ff[PW-1];
      hi1  = !lo1 && (num1_ff > den_ff);
      out0 = lo0 || hi0;
      out1 = lo1 || hi1;
      if (!gen) begin
         n0_in = zero; d0s_in = one;
         n1_in = fw;   d1s_in = ew;
      end else if (out0 && out1) begin
         n0_in = lo0 ? zero : one; d0s_in = one;
         n1_in = lo1 ? zero : one; d1s_in = one;
      end else if (out0) begin
         n0_in = lo0 ? zero : one; d0s_in = one;
         n1_in = fw + (lo0 ? zero : bw); d1s_in = ew;
      end else if (out1) begin
         n1_in = lo1 ? zero : one; d1s_in = one;
         n0_in = (lo1 ? zero : bw) - cw_; d0s_in = aw;
      end else begin
         n0_in = num0_ff; d0s_in = den_ff;
         n1_in = num1_ff; d1s_in = den_ff;
      end
   end

   // stage 6: clamp to [0,1]
   logic [UW-1:0] nu0_in, du0_in, nu1_in, du1_in;
   logic [UW-1:0] nu0_ff, du0_ff, nu1_ff, du1_ff;

   always_comb begin
      if (d0s_ff == '0 || n0_ff[PW-1]) begin
         nu0_in = '0; du0_in = UW'(1);
      end else if (n0_ff >= d0s_ff) begin
         nu0_in = UW'(1); du0_in = UW'(1);
      end else begin
         nu0_in = n0_ff[UW-1:0]; du0_in = d0s_ff[UW-1:0];
      end
      if (d1s_ff == '0 || n1_ff[PW-1]) begin
         nu1_in = '0; du1_in = UW'(1);
      end else if (n1_ff >= d1s_ff) begin
         nu1_in = UW'(1); du1_in = UW'(1);
      end else begin
         nu1_in = n1_ff[UW-1:0]; du1_in = d1s_ff[UW-1:0];
      end
   end

   cco_pkg::frac_type t0, t1;

   cco_divider #(.DEN_WIDTH(UW)) u_div_t0 (
      .clock(clock), .enable(en), .num_in(nu0_ff), .den_in(du0_ff), .quot_out(t0)
   );
   cco_divider #(.DEN_WIDTH(UW)) u_div_t1 (
      .clock(clock), .enable(en), .num_in(nu1_ff), .den_in(du1_ff), .quot_out(t1)
   );

   // gap vector, squares, compare
   logic signed [GW-1:0] g_in [3];
   logic signed [GW-1:0] g_ff [3];
   logic [RSW-1:0] rs_g_ff;
   logic [SQW-1:0] sq_ff [3];
   logic [SUMW-1:0] rr_ff;
   logic ov_ff, ov_in;

   always_comb begin
      logic signed [DW-1:0] d0, d1, vv;
      for (int k = 0; k < 3; k++) begin
         d0 = $signed(side_ff[SIDE_N-1][k*DW +: DW]);
         d1 = $signed(side_ff[SIDE_N-1][(3+k)*DW +: DW]);
         vv = $signed(side_ff[SIDE_N-1][(6+k)*DW +: DW]);
         g_in[k] = GW'(d1) * GW'($signed({1'b0, t1}))
                 - GW'(d0) * GW'($signed({1'b0, t0}))
                 - (GW'(vv) <<< cco_pkg::T_SHIFT);
      end
   end

   assign ov_in = (SUMW'(sq_ff[0]) + SUMW'(sq_ff[1]) + SUMW'(sq_ff[2])) <= rr_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < SIDE_N; i++) side_ff[i] <= side_ff[i-1];
         a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; e_ff <= e_in; f_ff <= f_in;
         ae_ff <= PW'(a_ff) * PW'(e_ff);
         bb_ff <= PW'(b_ff) * PW'(b_ff);
         bf_ff <= PW'(b_ff) * PW'(f_ff);
         ce_ff <= PW'(c_ff) * PW'(e_ff);
         af_ff <= PW'(a_ff) * PW'(f_ff);
         bc_ff <= PW'(b_ff) * PW'(c_ff);
         a3_ff <= a_ff; b3_ff <= b_ff; c3_ff <= c_ff; e3_ff <= e_ff; f3_ff <= f_ff;
         den_ff  <= ae_ff - bb_ff;
         num0_ff <= bf_ff - ce_ff;
         num1_ff <= af_ff - bc_ff;
         a4_ff <= a3_ff; b4_ff <= b3_ff; c4_ff <= c3_ff; e4_ff <= e3_ff; f4_ff <= f3_ff;
         n0_ff <= n0_in; d0s_ff <= d0s_in; n1_ff <= n1_in; d1s_ff <= d1s_in;
         nu0_ff <= nu0_in; du0_ff <= du0_in; nu1_ff <= nu1_in; du1_ff <= du1_in;
         for (int k = 0; k < 3; k++) begin
            g_ff[k]  <= g_in[k];
            sq_ff[k] <= SQW'(g_ff[k] * g_ff[k]);
         end
         rs_g_ff <= side_ff[SIDE_N-1][9*DW +: RSW];
         rr_ff   <= (SUMW'(rs_g_ff) * SUMW'(rs_g_ff)) << (2 * cco_pkg::T_SHIFT);
         ov_ff   <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NST-2:0], acc};
      end
   end

   // output register with skid
   logic take;
   assign take = rsp_bus.ready || !rsp_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (take) begin
         if (skid_v_ff) begin
            rsp_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            rsp_v_ff <= v_ff[NST-1];
         end
      end else if (v_ff[NST-1]) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_d_ff <= skid_v_ff ? skid_d_ff : ov_ff;
      end else if (en) begin
         skid_d_ff <= ov_ff;
      end
   end

   assign rsp_bus.valid   = rsp_v_ff;
   assign rsp_bus.overlap = rsp_d_ff;

endmodule

[hw/rtl/cco_divider.sv]
`timescale 1ns / 1ps

// restoring divider, one quotient bit per stage, num <= den, den > 0
module cco_divider #(
   parameter int DEN_WIDTH = 76
) (
   input  logic                   clock,
   input  logic                   enable,
   input  logic [DEN_WIDTH-1:0]   num_in,
   input  logic [DEN_WIDTH-1:0]   den_in,
   output cco_pkg::frac_type      quot_out
);

   localparam int RW = DEN_WIDTH + 1;
   localparam int NS = cco_pkg::DIV_STEPS;

   logic [RW-1:0]        rem_ff  [NS];
   logic [DEN_WIDTH-1:0] den_ff  [NS];
   cco_pkg::frac_type    quot_ff [NS];

   logic [RW-1:0]        rem_in  [NS];
   cco_pkg::frac_type    quot_in [NS];

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         logic [RW-1:0]        r;
         logic [DEN_WIDTH-1:0] d;
         cco_pkg::frac_type    q;
         logic                 ge;
         logic [RW-1:0]        rn;
         if (i == 0) begin
            r = {1'b0, num_in};
            d = den_in;
            q = '0;
         end else begin
            r = rem_ff[i-1];
            d = den_ff[i-1];
            q = quot_ff[i-1];
         end
         ge = (r >= {1'b0, d});
         rn = ge ? (r - {1'b0, d}) : r;
         rem_in[i]  = {rn[RW-2:0], 1'b0};
         quot_in[i] = {q[cco_pkg::T_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < NS; i++) begin
            rem_ff[i]  <= rem_in[i];
            quot_ff[i] <= quot_in[i];
            den_ff[i]  <= (i == 0) ? den_in : den_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   assign quot_out = quot_ff[NS-1];

endmodule

[hw/rtl/cco_checker.sv]
`timescale 1ns / 1ps
`include "capsule_capsule_overlap_macros.svh"

module cco_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_overlap
);

   `CCO_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_overlap))
   `CCO_ASSERT_NOW(a_busy_has_rsp, !req_ready, rsp_valid)
   `CCO_ASSERT_NOW(a_busy_after_stall, !req_ready, $past(rsp_valid && !rsp_ready))
   `CCO_ASSERT_NOW(a_ready_on_take, $rose(req_ready) && !$past(reset), $past(rsp_ready))
   `CCO_ASSERT_NOW(a_wait_has_rsp, req_valid && !req_ready, rsp_valid)

endmodule

bind capsule_capsule_overlap cco_checker u_cco_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_bus.valid),
   .req_ready(req_bus.ready),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .rsp_overlap(rsp_bus.overlap)
);

[tb/capsule_overlap_scoreboard.sv]
`timescale 1ns / 1ps

class capsule_overlap_scoreboard;
   bit pending_overlap[$];
   int mismatch_count;
   int stray_count;

   function new();
      mismatch_count = 0;
      stray_count = 0;
   endfunction

   function void note_pair(bit overlap);
      pending_overlap.push_back(overlap);
   endfunction

   function void check_overlap(bit actual);
      bit want;
      if (pending_overlap.size() == 0) begin
         stray_count++;
         if (mismatch_count + stray_count <= 10)
            $display("unexpected overlap beat %0b", actual);
         return;
      end
      want = pending_overlap.pop_front();
      if (want !== actual) begin
         mismatch_count++;
         if (mismatch_count + stray_count <= 10)
            $display("overlap mismatch: expected %0b actual %0b", want, actual);
      end
   endfunction

   function int failures();
      return mismatch_count + stray_count + pending_overlap.size();
   endfunction
endclass

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   localparam int CW = 16;
   localparam longint T_ONE = 65536;
   localparam int LIMIT = 2000000;

   logic clock;
   logic reset;
   cco_req_if req_bus();
   cco_rsp_if rsp_bus();

   capsule_capsule_overlap #(.COORD_WIDTH(CW)) dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source)
   );

   capsule_overlap_scoreboard board = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int cycle_count = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic logic signed [127:0] coord_of(logic [47:0] p, int k);
      logic signed [15:0] c;
      c = p[k*CW +: CW];
      return 128'(c);
   endfunction

   function automatic longint frac_div(logic signed [127:0] num, logic signed [127:0] den);
      logic signed [127:0] q;
      if (den == 0 || num < 0) return 0;
      if (num >= den) return T_ONE;
      q = (num * T_ONE) / den;
      return longint'(q);
   endfunction

   function automatic bit capsules_touch(logic [47:0] as, logic [47:0] ae, logic [15:0] ra,
                                         logic [47:0] bs, logic [47:0] be, logic [15:0] rb);
      logic signed [127:0] d0[3], d1[3], v[3];
      logic signed [127:0] a, b, c, e, f, den, n0, n1, g, sum, rs;
      longint t0, t1;
      bit lo0, hi0, lo1, hi1;
      a = 0; b = 0; c = 0; e = 0; f = 0;
      for (int k = 0; k < 3; k++) begin
         d0[k] = coord_of(ae, k) - coord_of(as, k);
         d1[k] = coord_of(be, k) - coord_of(bs, k);
         v[k] = coord_of(as, k) - coord_of(bs, k);
         a += d0[k] * d0[k];
         b += d0[k] * d1[k];
         c += d0[k] * v[k];
         e += d1[k] * d1[k];
         f += d1[k] * v[k];
      end
      den = a * e - b * b;
      n0 = b * f - c * e;
      n1 = a * f - b * c;
      if (den <= 0) begin
         t0 = 0;
         t1 = frac_div(f, e);
      end else begin
         lo0 = n0 < 0;
         hi0 = !lo0 && n0 > den;
         lo1 = n1 < 0;
         hi1 = !lo1 && n1 > den;
         if ((lo0 || hi0) && (lo1 || hi1)) begin
            t0 = lo0 ? 0 : T_ONE;
            t1 = lo1 ? 0 : T_ONE;
         end else if (lo0 || hi0) begin
            t0 = lo0 ? 0 : T_ONE;
            t1 = frac_div(f + (lo0 ? 128'sd0 : b), e);
         end else if (lo1 || hi1) begin
            t1 = lo1 ? 0 : T_ONE;
            t0 = frac_div((lo1 ? 128'sd0 : b) - c, a);
         end else begin
            t0 = longint'((n0 * T_ONE) / den);
            t1 = longint'((n1 * T_ONE) / den);
         end
      end
      sum = 0;
      for (int k = 0; k < 3; k++) begin
         g = -v[k] * T_ONE + d1[k] * t1 - d0[k] * t0;
         sum += g * g;
      end
      rs = (128'(ra) + 128'(rb)) * T_ONE;
      return sum <= rs * rs;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) board.check_overlap(rsp_bus.overlap);
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [47:0] rand_point(int mode);
      logic [47:0] p;
      for (int k = 0; k < 3; k++) begin
         case (mode)
            0: p[k*CW +: CW] = 16'($urandom);
            default: p[k*CW +: CW] = 16'($signed($urandom_range(2047)) - 1024);
         endcase
      end
      return p;
   endfunction

   task automatic send_pair(logic [47:0] as, logic [47:0] ae, logic [15:0] ra,
                            logic [47:0] bs, logic [47:0] be, logic [15:0] rb);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.seg_a_start <= as;
      req_bus.seg_a_end <= ae;
      req_bus.radius_a <= ra;
      req_bus.seg_b_start <= bs;
      req_bus.seg_b_end <= be;
      req_bus.radius_b <= rb;
      do @(posedge clock); while (!req_bus.ready);
      board.note_pair(capsules_touch(as, ae, ra, bs, be, rb));
   endtask

   task automatic send_random(int count);
      logic [47:0] as, ae, bs, be;
      int mode;
      for (int i = 0; i < count; i++) begin
         mode = $urandom_range(3);
         as = rand_point(mode);
         ae = ($urandom_range(9) == 0) ? as : rand_point(mode);
         bs = rand_point(mode);
         case ($urandom_range(5))
            0: be = bs;
            1: be = bs + (ae - as);
            default: be = rand_point(mode);
         endcase
         send_pair(as, ae, (mode == 0) ? 16'($urandom) : 16'($urandom_range(1023)),
                   bs, be, (mode == 0) ? 16'($urandom) : 16'($urandom_range(1023)));
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.seg_a_start = '0;
      req_bus.seg_a_end = '0;
      req_bus.radius_a = '0;
      req_bus.seg_b_start = '0;
      req_bus.seg_b_end = '0;
      req_bus.radius_b = '0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // extremes, degenerate, parallel, crossing, clamped ends
      send_pair('0, '0, '0, '0, '0, '0);
      send_pair('1, '1, 16'hffff, '0, '0, 16'hffff);
      send_pair({3{16'h8000}}, {3{16'h7fff}}, '0, {3{16'h7fff}}, {3{16'h8000}}, '0);
      send_pair({3{16'h8000}}, {3{16'h7fff}}, 16'h0100,
                {16'h0, 16'h0100, 16'h0}, {16'h0, 16'h0100, 16'h0100}, 16'h0100);
      send_pair(48'h0, 48'h0000_0000_0400, 16'h0080,
                48'h0000_0100_0200, 48'h0000_0100_0600, 16'h0080);
      send_pair(48'h0, 48'h0000_0000_0400, 16'h0080,
                48'h0000_0100_0200, 48'h0000_0100_0200, 16'h0080);
      send_pair(48'h0, 48'h0, 16'h0100, 48'h0000_0000_0100, 48'h0000_0000_0100, 16'h0);
      send_pair(48'h0, 48'h0000_0000_0100, 16'h0001,
                48'h0000_0100_0080, 48'h0000_ff00_0080, 16'h0);
      send_pair(48'h0, 48'h0000_0000_0100, 16'h0080,
                48'h0000_0100_0400, 48'h0000_ff00_0400, 16'h0080);
      send_pair(48'h0, 48'h0000_0000_0100, 16'h0080,
                48'h0000_0100_ff00, 48'h0000_ff00_fe00, 16'h0080);
      send_pair(48'h0000_0000_0400, 48'h0, 16'h0200,
                48'h0000_0400_0200, 48'h0000_0800_0200, 16'h0200);
      send_pair(48'h0000_0000_0400, 48'h0, 16'h0100,
                48'h0000_0400_0200, 48'h0000_0800_0200, 16'h0100);

      send_idle_pct = 0;  recv_stall_pct = 0;  send_random(350);
      send_idle_pct = 82; recv_stall_pct = 0;  send_random(350);
      send_idle_pct = 0;  recv_stall_pct = 82; send_random(350);
      send_idle_pct = 9;  recv_stall_pct = 9;  send_random(350);
      req_bus.valid <= 1'b0;

      while (board.pending_overlap.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.failures() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/cco_pkg.sv
hw/rtl/cco_req_if.sv
hw/rtl/cco_rsp_if.sv
hw/rtl/cco_divider.sv
hw/rtl/capsule_capsule_overlap.sv
hw/rtl/cco_checker.sv
tb/capsule_overlap_scoreboard.sv
tb/testbench.sv
